// ===== sv/bcf_pkg.sv =====
`timescale 1ns / 1ps
package bcf_pkg;

   localparam int STEPS     = 24;
   localparam int FRAC_BITS = 16;

   localparam int COORD_W  = 32;
   localparam int THRESH_W = 32;
   localparam int NEAR_W   = THRESH_W / 2;
   localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int WEIGHT_W = FRAC_BITS + 1;
   localparam int PROD_W   = WEIGHT_W + 1 + COORD_W;
   localparam int SUM_W    = PROD_W + 2;

   localparam longint unsigned DEN2 = longint'(STEPS) * longint'(STEPS);
   localparam longint unsigned DEN3 = DEN2 * longint'(STEPS);

   localparam logic KIND_CUBIC = 1'b0;
   localparam logic KIND_QUAD  = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [COORD_W-1:0]        coord_bits_type;
   typedef coord_bits_type [7:0]      point_set_type;
   typedef logic [WEIGHT_W-1:0]       weight_type;
   typedef weight_type [3:0]          weight_set_type;
   typedef weight_set_type [STEPS-1:0] weight_col_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic      operation;
      coord_type p0_x;
      coord_type p0_y;
      coord_type p1_x;
      coord_type p1_y;
      coord_type p2_x;
      coord_type p2_y;
      coord_type p3_x;
      coord_type p3_y;
   } req_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      logic      duplicate;
      logic      last;
   } rsp_type;

   // one step of a curve: Bernstein weights plus control points (x0,y0,..,x3,y3)
   typedef struct packed {
      weight_set_type weights;
      point_set_type  points;
      logic           first;
      logic           last;
   } step_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type start_x;
      coord_type start_y;
      logic      first;
      logic      last;
   } point_type;

   function automatic weight_col_type build_weights(input logic kind);
      weight_col_type  t;
      longint unsigned i;
      longint unsigned u;
      longint unsigned w;
      longint unsigned c [4];
      for (int s = 0; s < STEPS; s++) begin
         i = longint'(s + 1);
         u = longint'(STEPS) - i;
         if (kind == KIND_CUBIC) begin
            c[0] = u * u * u;
            c[1] = 64'd3 * u * u * i;
            c[2] = 64'd3 * u * i * i;
            c[3] = i * i * i;
         end else begin
            c[0] = u * u;
            c[1] = 64'd2 * u * i;
            c[2] = i * i;
            c[3] = 64'd0;
         end
         for (int k = 0; k < 4; k++) begin
            if (kind == KIND_CUBIC) begin
               w = ((c[k] << FRAC_BITS) + DEN3 / 2) / DEN3;
            end else begin
               w = ((c[k] << FRAC_BITS) + DEN2 / 2) / DEN2;
            end
            t[s][k] = w[WEIGHT_W-1:0];
         end
      end
      return t;
   endfunction

   localparam weight_col_type CUBIC_WEIGHTS = build_weights(KIND_CUBIC);
   localparam weight_col_type QUAD_WEIGHTS  = build_weights(KIND_QUAD);

endpackage

// ===== sv/bcf_seq.sv =====
`timescale 1ns / 1ps
module bcf_seq import bcf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     out_valid,
   input  logic     out_ready,
   output step_type out_data
);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              kind_ff;
   point_set_type     pts_ff;
   logic              s1_valid_ff, s1_valid_in;
   step_type          s1_ff;

   logic issue;
   logic issue_last;
   logic take;

   assign issue      = busy_ff && (!s1_valid_ff || out_ready);
   assign issue_last = (step_ff == STEP_W'(STEPS - 1));
   assign req_ready  = !busy_ff || (issue && issue_last);
   assign take       = req_valid && req_ready;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (issue) begin
         step_in = issue_last ? '0 : step_ff + 1'b1;
         if (issue_last) begin
            busy_in = 1'b0;
         end
      end
      if (take) begin
         busy_in = 1'b1;
         step_in = '0;
      end
      s1_valid_in = issue ? 1'b1 : (out_ready ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         step_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         step_ff     <= step_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff   <= req_data.operation;
         pts_ff[0] <= req_data.p0_x;
         pts_ff[1] <= req_data.p0_y;
         pts_ff[2] <= req_data.p1_x;
         pts_ff[3] <= req_data.p1_y;
         pts_ff[4] <= req_data.p2_x;
         pts_ff[5] <= req_data.p2_y;
         pts_ff[6] <= (req_data.operation == KIND_QUAD) ? '0 : req_data.p3_x;
         pts_ff[7] <= (req_data.operation == KIND_QUAD) ? '0 : req_data.p3_y;
      end
      if (issue) begin
         s1_ff.weights <= (kind_ff == KIND_QUAD) ? QUAD_WEIGHTS[step_ff]
                                                 : CUBIC_WEIGHTS[step_ff];
         s1_ff.points  <= pts_ff;
         s1_ff.first   <= (step_ff == '0);
         s1_ff.last    <= issue_last;
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_data  = s1_ff;

endmodule

// ===== sv/bcf_mac.sv =====
`timescale 1ns / 1ps
module bcf_mac import bcf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  step_type  in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output point_type out_data
);

   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] prod_x_ff [4];
   logic signed [PROD_W-1:0] prod_y_ff [4];
   coord_type                start_x_ff, start_y_ff;
   logic                     first_ff, last_ff;
   logic                     s3_valid_ff;
   point_type                s3_ff;

   logic                     s2_ready, s3_ready;
   logic                     s2_load, s3_load;
   logic signed [SUM_W-1:0]  sum_x, sum_y;

   function automatic coord_type round_sat(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0]   r;
      logic signed [SUM_W-1:0]   q;
      logic [SUM_W-COORD_W:0]    upper;
      coord_type                 res;
      r     = s + $signed({{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});
      q     = r >>> FRAC_BITS;
      upper = q[SUM_W-1:COORD_W-1];
      if (&upper || ~|upper) begin
         res = q[COORD_W-1:0];
      end else begin
         res = q[SUM_W-1] ? COORD_MIN : COORD_MAX;
      end
      return res;
   endfunction

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign in_ready = s2_ready;
   assign s2_load  = in_valid && s2_ready;
   assign s3_load  = s2_valid_ff && s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= in_valid;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         for (int k = 0; k < 4; k++) begin
            prod_x_ff[k] <= $signed({1'b0, in_data.weights[k]})
                            * $signed(in_data.points[2*k]);
            prod_y_ff[k] <= $signed({1'b0, in_data.weights[k]})
                            * $signed(in_data.points[2*k+1]);
         end
         start_x_ff <= in_data.points[0];
         start_y_ff <= in_data.points[1];
         first_ff   <= in_data.first;
         last_ff    <= in_data.last;
      end
   end

   always_comb begin
      sum_x = '0;
      sum_y = '0;
      for (int k = 0; k < 4; k++) begin
         sum_x = sum_x + SUM_W'(prod_x_ff[k]);
         sum_y = sum_y + SUM_W'(prod_y_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_ff.x       <= round_sat(sum_x);
         s3_ff.y       <= round_sat(sum_y);
         s3_ff.start_x <= start_x_ff;
         s3_ff.start_y <= start_y_ff;
         s3_ff.first   <= first_ff;
         s3_ff.last    <= last_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

// ===== sv/bcf_dedup.sv =====
`timescale 1ns / 1ps
module bcf_dedup import bcf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data,
   input  logic                in_valid,
   output logic                in_ready,
   input  point_type           in_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data
);

   logic [THRESH_W-1:0] thresh_ff;
   coord_type           kept_x_ff, kept_x_in;
   coord_type           kept_y_ff, kept_y_in;
   logic                out_valid_ff;
   rsp_type             out_ff;

   logic                   load;
   coord_type              ref_x, ref_y;
   logic signed [COORD_W:0] diff_x, diff_y;
   logic [COORD_W:0]       mag_x, mag_y;
   logic [THRESH_W-1:0]    sq_x, sq_y;
   logic [THRESH_W:0]      sum_sq;
   logic                   near, dup;

   assign in_ready = !out_valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;

   // kept point restarts at p0 on the first step of each curve
   always_comb begin
      ref_x  = in_data.first ? in_data.start_x : kept_x_ff;
      ref_y  = in_data.first ? in_data.start_y : kept_y_ff;
      diff_x = $signed({ref_x[COORD_W-1], ref_x}) - $signed({in_data.x[COORD_W-1], in_data.x});
      diff_y = $signed({ref_y[COORD_W-1], ref_y}) - $signed({in_data.y[COORD_W-1], in_data.y});
      mag_x  = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : diff_x;
      mag_y  = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : diff_y;
      // a component of 2^16 or more already squares past any threshold
      near   = (mag_x[COORD_W:NEAR_W] == '0) && (mag_y[COORD_W:NEAR_W] == '0);
      sq_x   = mag_x[NEAR_W-1:0] * mag_x[NEAR_W-1:0];
      sq_y   = mag_y[NEAR_W-1:0] * mag_y[NEAR_W-1:0];
      sum_sq = {1'b0, sq_x} + {1'b0, sq_y};
      dup    = near && (sum_sq <= {1'b0, thresh_ff});
      kept_x_in = dup ? ref_x : in_data.x;
      kept_y_in = dup ? ref_y : in_data.y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= '0;
         out_valid_ff <= 1'b0;
         kept_x_ff    <= '0;
         kept_y_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
         if (load) begin
            kept_x_ff <= kept_x_in;
            kept_y_ff <= kept_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff.out_x     <= in_data.x;
         out_ff.out_y     <= in_data.y;
         out_ff.duplicate <= dup;
         out_ff.last      <= in_data.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== sv/bezier_curve_flattener.sv =====
`timescale 1ns / 1ps
// Bezier curve flattener, uniform parameter steps.
//
// req_*: one curve per transfer (cubic or quadratic, Q16.16 control points).
// rsp_*: STEPS (24) points per curve, one per transfer, the final one with
//        last set; duplicate marks a point within the squared-distance
//        threshold of the last kept point, which restarts at p0 each curve.
// csr_*: csr_wr_data is the duplicate threshold, written when csr_wr_en is
//        high; write it only while no curve is in flight.
//
// Throughput: one point per cycle while rsp_ready stays high; the next
// curve is taken in the cycle its predecessor's last step issues, so
// back-to-back curves stream without gaps. The rate is set by the step
// sequencer, which issues one step per cycle when the pipeline is not
// stalled, into a four-stage pipeline (weight lookup, multiply, sum and
// round, dedup and output register).
//
// Synchronous reset clears all valid bits, the sequencer and the threshold.
// When rsp_ready is low the pipeline fills and then holds; nothing is lost
// or repeated. req_ready is high only while the sequencer is idle or issues
// the last step of the current curve.
module bezier_curve_flattener import bcf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data
);

   logic      step_valid, step_ready;
   step_type  step_data;
   logic      point_valid, point_ready;
   point_type point_data;

   bcf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (step_valid),
      .out_ready (step_ready),
      .out_data  (step_data)
   );

   bcf_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .in_ready  (step_ready),
      .in_data   (step_data),
      .out_valid (point_valid),
      .out_ready (point_ready),
      .out_data  (point_data)
   );

   bcf_dedup u_dedup (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (point_valid),
      .in_ready    (point_ready),
      .in_data     (point_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== sv/bcf_checker.sv =====
`timescale 1ns / 1ps
module bcf_checker import bcf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam int PEND_W = $clog2(3 * STEPS);

   logic [STEP_W-1:0] out_count_ff;
   logic [PEND_W-1:0] pending_ff;
   logic              req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff <= '0;
         pending_ff   <= '0;
      end else begin
         if (rsp_xfer) begin
            out_count_ff <= (out_count_ff == STEP_W'(STEPS - 1)) ? '0 : out_count_ff + 1'b1;
         end
         pending_ff <= pending_ff + (req_xfer ? PEND_W'(STEPS) : '0) - PEND_W'(rsp_xfer);
      end
   end

   // points come out only for curves that were taken
   a_no_orphan_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("point without an outstanding curve");

   // last marks every STEPS-th point transfer
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> rsp_data.last == (out_count_ff == STEP_W'(STEPS - 1)))
      else $error("last flag out of step");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind bezier_curve_flattener bcf_checker u_bcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/bezier_curve_flattener_tb.sv =====
`timescale 1ns / 1ps
module bezier_curve_flattener_tb;
   import bcf_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [THRESH_W-1:0] csr_wr_data = '0;

   rsp_type             expected_points[$];
   logic [THRESH_W-1:0] dup_threshold  = '0;
   int                  errors         = 0;
   int                  send_idle_pct  = 0;
   int                  recv_stall_pct = 0;
   int                  hold_orders    = 0;
   int                  hold_length    = 0;

   bezier_curve_flattener DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   function automatic longint unsigned bern_weight(input longint unsigned num,
                                                   input longint unsigned den);
      return ((num << FRAC_BITS) + den / 2) / den;
   endfunction

   function automatic coord_type round_sat(input longint s);
      longint q;
      q = (s + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (q > longint'(COORD_MAX)) return COORD_MAX;
      if (q < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(q);
   endfunction

   function automatic logic [63:0] sq_mag(input longint d);
      logic [63:0] m;
      m = (d < 0) ? -d : d;
      return m * m;
   endfunction

   // 24 points per curve; kept point restarts at p0
   function automatic void predict_curve(input req_type c);
      longint            pt [8];
      longint unsigned   num [4];
      longint unsigned   i, u, den;
      longint            w, sx, sy, kx, ky;
      coord_type         cx, cy;
      logic [64:0]       d;
      rsp_type           r;
      int                s, k;
      pt[0] = c.p0_x; pt[1] = c.p0_y;
      pt[2] = c.p1_x; pt[3] = c.p1_y;
      pt[4] = c.p2_x; pt[5] = c.p2_y;
      pt[6] = c.p3_x; pt[7] = c.p3_y;
      if (c.operation == KIND_QUAD) begin
         pt[6] = 0;
         pt[7] = 0;
      end
      kx = pt[0];
      ky = pt[1];
      for (s = 1; s <= STEPS; s++) begin
         i = s;
         u = STEPS - s;
         if (c.operation == KIND_CUBIC) begin
            den    = longint'(STEPS) * STEPS * STEPS;
            num[0] = u * u * u;
            num[1] = 64'd3 * u * u * i;
            num[2] = 64'd3 * u * i * i;
            num[3] = i * i * i;
         end else begin
            den    = longint'(STEPS) * STEPS;
            num[0] = u * u;
            num[1] = 64'd2 * u * i;
            num[2] = i * i;
            num[3] = 0;
         end
         sx = 0;
         sy = 0;
         for (k = 0; k < 4; k++) begin
            w  = longint'(bern_weight(num[k], den));
            sx = sx + w * pt[2*k];
            sy = sy + w * pt[2*k+1];
         end
         cx = round_sat(sx);
         cy = round_sat(sy);
         d = {1'b0, sq_mag(kx - longint'(cx))} + {1'b0, sq_mag(ky - longint'(cy))};
         if (d[64]) d = {1'b0, {64{1'b1}}};
         r.out_x     = cx;
         r.out_y     = cy;
         r.duplicate = (d[63:0] <= {32'd0, dup_threshold});
         r.last      = (s == STEPS);
         if (!r.duplicate) begin
            kx = cx;
            ky = cy;
         end
         expected_points.insert(expected_points.size(), r);
      end
   endfunction

   function automatic req_type make_curve(input logic op,
         input coord_type x0, input coord_type y0, input coord_type x1, input coord_type y1,
         input coord_type x2, input coord_type y2, input coord_type x3, input coord_type y3);
      req_type c;
      c.operation = op;
      c.p0_x = x0; c.p0_y = y0;
      c.p1_x = x1; c.p1_y = y1;
      c.p2_x = x2; c.p2_y = y2;
      c.p3_x = x3; c.p3_y = y3;
      return c;
   endfunction

   function automatic coord_type jitter(input coord_type base, input int span);
      return base + coord_type'(int'($urandom_range(2 * span)) - span);
   endfunction

   // wide random, clustered, or tightly clustered (duplicates likely)
   function automatic req_type random_curve();
      req_type   c;
      coord_type bx, by;
      int        pick, span;
      pick = $urandom_range(99);
      c.operation = 1'($urandom_range(1));
      if (pick < 40) begin
         c.p0_x = $urandom; c.p0_y = $urandom;
         c.p1_x = $urandom; c.p1_y = $urandom;
         c.p2_x = $urandom; c.p2_y = $urandom;
         c.p3_x = $urandom; c.p3_y = $urandom;
      end else begin
         span = (pick < 80) ? (1 << 17) : 8;
         bx = $urandom;
         by = $urandom;
         c.p0_x = jitter(bx, span); c.p0_y = jitter(by, span);
         c.p1_x = jitter(bx, span); c.p1_y = jitter(by, span);
         c.p2_x = jitter(bx, span); c.p2_y = jitter(by, span);
         c.p3_x = jitter(bx, span); c.p3_y = jitter(by, span);
      end
      return c;
   endfunction

   task automatic send_curve(input req_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_curve(c);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [THRESH_W-1:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dup_threshold = v;
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      errors++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
   endtask

   task automatic test_directed_extremes();
      coord_type one;
      one = 32'sh0001_0000;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // reset threshold: only exact repeats are duplicates
      send_curve(make_curve(KIND_CUBIC, 0, 0, 0, 0, 0, 0, 0, 0));
      send_curve(make_curve(KIND_CUBIC, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_curve(make_curve(KIND_CUBIC, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_curve(make_curve(KIND_QUAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
      send_curve(make_curve(KIND_QUAD, 0, 0, one, -one, -one, one, $urandom, $urandom));
      send_curve(make_curve(KIND_CUBIC, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_curve(make_curve(KIND_CUBIC, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_curve(make_curve(KIND_CUBIC, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                            COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
      send_curve(make_curve(KIND_CUBIC, 0, 0, 1, -1, 2, -2, 3, -3));
      send_curve(make_curve(KIND_CUBIC, 0, 0, 32'sh5555, 0, 32'shAAAA, 0, one, 0));
      send_curve(make_curve(KIND_QUAD, -1, -1, -2, -2, -3, -3, 0, 0));
      // widest threshold: a squared distance under 2^32 is a duplicate, a larger one never
      set_threshold('1);
      send_curve(make_curve(KIND_CUBIC, 0, 0, 1, -1, 2, -2, 3, -3));
      send_curve(make_curve(KIND_CUBIC, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_curve(make_curve(KIND_CUBIC, 0, 0, 32'sh5555, 0, 32'shAAAA, 0, one, 0));
      set_threshold(32'h0000_4000);
      send_curve(make_curve(KIND_CUBIC, 0, 0, 32'sh5555, 0, 32'shAAAA, 0, one, 0));
      send_curve(make_curve(KIND_QUAD, 0, 0, one, one, 2 * one, 0, 0, 0));
   endtask

   task automatic test_random_phases();
      logic [THRESH_W-1:0] thr [8];
      int                  send_pct [4];
      int                  recv_pct [4];
      int                  p, h;
      thr = '{32'h0, 32'h0001_0000, 32'h0100_0000, 32'hFFFF_FFFF,
              $urandom, 32'h0000_0040, 32'h4000_0000, $urandom};
      send_pct = '{0, 59, 0, 34};
      recv_pct = '{0, 0, 59, 34};
      for (p = 0; p < 4; p++) begin
         for (h = 0; h < 2; h++) begin
            set_threshold(thr[2*p+h]);
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            repeat (42) send_curve(random_curve());
         end
      end
   endtask

   // receiver holds off while the sender keeps offering curves
   task automatic test_fill_and_stall();
      set_threshold(32'h0010_0000);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_length    = 400;
      hold_orders++;
      repeat (16) send_curve(random_curve());
      wait_drained();
   endtask

   task automatic test_drain_pause();
      send_idle_pct  = 34;
      recv_stall_pct = 34;
      repeat (10) send_curve(random_curve());
      wait_drained();
      repeat (10) send_curve(random_curve());
   endtask

   always @(posedge clock) begin : drive_ready
      static int hold_taken = 0;
      static int hold_left  = 0;
      if (hold_taken != hold_orders) begin
         hold_taken = hold_orders;
         hold_left  = hold_length;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_points
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            errors++;
            $display("%0t: unexpected point x=%h y=%h dup=%b last=%b", $time,
                     rsp_data.out_x, rsp_data.out_y, rsp_data.duplicate, rsp_data.last);
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.out_x !== want.out_x)
               note_mismatch("out_x", want.out_x, rsp_data.out_x);
            if (rsp_data.out_y !== want.out_y)
               note_mismatch("out_y", want.out_y, rsp_data.out_y);
            if (rsp_data.duplicate !== want.duplicate)
               note_mismatch("duplicate", {31'd0, want.duplicate},
                             {31'd0, rsp_data.duplicate});
            if (rsp_data.last !== want.last)
               note_mismatch("last", {31'd0, want.last}, {31'd0, rsp_data.last});
         end
      end
   end

   always @(posedge clock) begin : watchdog
      static int idle_cycles = 0;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_random_phases();
      test_fill_and_stall();
      test_drain_pause();
      wait_drained();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bcf_pkg.sv
sv/bcf_seq.sv
sv/bcf_mac.sv
sv/bcf_dedup.sv
sv/bezier_curve_flattener.sv
sv/bcf_checker.sv
dv/bezier_curve_flattener_tb.sv
